@@ rtl/vsnf_pkg.sv @@
`default_nettype none
package vsnf_pkg;

  // Default volume dimensions
  localparam int MAX_X_DEF = 32;
  localparam int MAX_Y_DEF = 32;
  localparam int MAX_Z_DEF = 32;

  // Field widths
  localparam int COORD_W = 7;
  localparam int VOX_W   = 8;
  localparam int SIZE_W  = 6;
  localparam int STEP_W  = 5;
  localparam int DIFF_W  = 9;
  localparam int OFS_W   = 9;   // coordinate plus or minus step, signed
  localparam int LIM_W   = 10;  // clamp limit, holds up to 256

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_STEP   = 2'd3;

  // Reset values
  localparam logic [SIZE_W-1:0] SIZE_RST = 6'd32;
  localparam logic [STEP_W-1:0] STEP_RST = 5'd1;

  // Neighbor read order
  localparam logic [2:0] NB_RIGHT = 3'd0;
  localparam logic [2:0] NB_LEFT  = 3'd1;
  localparam logic [2:0] NB_UP    = 3'd2;
  localparam logic [2:0] NB_DOWN  = 3'd3;
  localparam logic [2:0] NB_FRONT = 3'd4;
  localparam logic [2:0] NB_BACK  = 3'd5;
  localparam int         NB_CNT   = 6;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } vsnf_size_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_RD,
    ST_LAST,
    ST_DONE
  } vsnf_state_t;

endpackage
`default_nettype wire

@@ rtl/vsnf_addr.sv @@
`default_nettype none
module vsnf_addr
  import vsnf_pkg::*;
#(
  parameter int MAX_X = MAX_X_DEF,
  parameter int MAX_Y = MAX_Y_DEF,
  parameter int MAX_Z = MAX_Z_DEF,
  parameter int AW    = 15
) (
  input  wire vsnf_size_t               sizes,
  input  wire logic signed [OFS_W-1:0]  cx,
  input  wire logic signed [OFS_W-1:0]  cy,
  input  wire logic signed [OFS_W-1:0]  cz,
  output logic             [AW-1:0]     addr
);

  localparam logic [LIM_W-1:0] LIM_MX = LIM_W'(MAX_X);
  localparam logic [LIM_W-1:0] LIM_MY = LIM_W'(MAX_Y);
  localparam logic [LIM_W-1:0] LIM_MZ = LIM_W'(MAX_Z);
  localparam logic [AW-1:0]    STR_X  = AW'(MAX_X);
  localparam logic [AW-1:0]    STR_Y  = AW'(MAX_Y);

  // size of 0 acts as 1, above the maximum acts as the maximum
  function automatic logic [LIM_W-1:0] limit_of(input logic [SIZE_W-1:0] sz,
                                                input logic [LIM_W-1:0]  mx);
    logic [LIM_W-1:0] s;
    s = LIM_W'(sz);
    if (s == '0) return LIM_W'(1);
    if (s > mx)  return mx;
    return s;
  endfunction

  function automatic logic [LIM_W-1:0] clamp(input logic signed [OFS_W-1:0] c,
                                             input logic [LIM_W-1:0]       lim);
    logic [LIM_W-1:0] cu;
    cu = LIM_W'(unsigned'(c));
    if (c < 0)     return '0;
    if (cu >= lim) return lim - LIM_W'(1);
    return cu;
  endfunction

  logic [LIM_W-1:0] lx, ly, lz;
  logic [AW-1:0]    ax, ay, az;

  always_comb begin
    lx = clamp(cx, limit_of(sizes.size_x, LIM_MX));
    ly = clamp(cy, limit_of(sizes.size_y, LIM_MY));
    lz = clamp(cz, limit_of(sizes.size_z, LIM_MZ));
    ax = AW'(lx);
    ay = AW'(ly);
    az = AW'(lz);
    addr = ax + STR_X * (ay + STR_Y * az);
  end

endmodule
`default_nettype wire

@@ rtl/volume_six_neighbor_fetch_unit.sv @@
`default_nettype none
// Voxel volume with a six-neighbor query. A write transaction (tuser = 0)
// stores one byte at a clamped (x,y,z) in ST_WR. A query (tuser = 1) reads
// the voxels at plus and minus step along each axis, all coordinates clamped
// to 0..size-1, and returns them with the three central differences. The
// single-port voxel RAM serves one read per cycle: six reads issue in ST_RD,
// read data is registered through ST_LAST, then ST_DONE loads the output
// register, stalling while an unaccepted result is held, then returns idle.
// The output register lets writes proceed while a result waits. The RAM is
// not cleared: voxels read back must have been written first.
module volume_six_neighbor_fetch_unit
  import vsnf_pkg::*;
#(
  parameter int MAX_X = MAX_X_DEF,
  parameter int MAX_Y = MAX_Y_DEF,
  parameter int MAX_Z = MAX_Z_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // coord_x[6:0], coord_y[13:7], coord_z[20:14], voxel_in[28:21], zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[0]
  input  wire logic [0:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // right_val[7:0], left_val[15:8], up_val[23:16], down_val[31:24],
  // front_val[39:32], back_val[47:40], diff_x[56:48], diff_y[65:57],
  // diff_z[74:66], zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_idx,
  input  wire logic [SIZE_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  vsnf_state_t state_r, state_nxt;

  vsnf_size_t        sizes_r;
  logic [STEP_W-1:0] step_r;

  logic signed [COORD_W-1:0] x_r, y_r, z_r;
  logic [VOX_W-1:0]          vox_r;
  logic [2:0]                idx_r;
  logic                      rd_vld_r;
  logic [2:0]                rd_idx_r;
  logic [VOX_W-1:0]          vals_r [NB_CNT];

  logic [VOX_W-1:0] mem [DEPTH];
  logic [VOX_W-1:0] rdata_r;
  logic [AW-1:0]    addr;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic in_acc, mem_we, mem_re, load_out;

  logic signed [OFS_W-1:0] sx, sy, sz, sstep;
  logic signed [OFS_W-1:0] ox, oy, oz;

  logic [DIFF_W-1:0] dx, dy, dz;

  assign in_acc = in_tvalid && in_tready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sizes_r.size_x <= SIZE_RST;
      sizes_r.size_y <= SIZE_RST;
      sizes_r.size_z <= SIZE_RST;
      step_r         <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SIZE_X: sizes_r.size_x <= cfg_data;
        REG_SIZE_Y: sizes_r.size_y <= cfg_data;
        REG_SIZE_Z: sizes_r.size_z <= cfg_data;
        REG_STEP:   step_r         <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = (in_tuser[0] == CMD_QUERY) ? ST_RD : ST_WR;
      ST_WR:   state_nxt = ST_IDLE;
      ST_RD:   if (idx_r == NB_BACK) state_nxt = ST_LAST;
      ST_LAST: state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_WR:   mem_we    = 1'b1;
      ST_RD:   mem_re    = 1'b1;
      ST_LAST: ;
      ST_DONE: load_out  = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= mem_re;
      if (in_acc)      idx_r <= '0;
      else if (mem_re) idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r   <= in_tdata[6:0];
      y_r   <= in_tdata[13:7];
      z_r   <= in_tdata[20:14];
      vox_r <= in_tdata[28:21];
    end
    rd_idx_r <= idx_r;
    if (rd_vld_r) vals_r[rd_idx_r] <= rdata_r;
  end

  // ---------------- neighbor address ----------------
  always_comb begin
    sx    = OFS_W'(x_r);
    sy    = OFS_W'(y_r);
    sz    = OFS_W'(z_r);
    sstep = signed'(OFS_W'(step_r));
    ox    = sx;
    oy    = sy;
    oz    = sz;
    if (state_r == ST_RD) begin
      case (idx_r)
        NB_RIGHT: ox = sx + sstep;
        NB_LEFT:  ox = sx - sstep;
        NB_UP:    oy = sy + sstep;
        NB_DOWN:  oy = sy - sstep;
        NB_FRONT: oz = sz + sstep;
        NB_BACK:  oz = sz - sstep;
        default: ;
      endcase
    end
  end

  vsnf_addr #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z),
    .AW    (AW)
  ) u_addr (
    .sizes (sizes_r),
    .cx    (ox),
    .cy    (oy),
    .cz    (oz),
    .addr  (addr)
  );

  // ---------------- voxel RAM, single port ----------------
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= vox_r;
    if (mem_re) rdata_r <= mem[addr];
  end

  // ---------------- output register ----------------
  assign dx = {1'b0, vals_r[NB_RIGHT]} - {1'b0, vals_r[NB_LEFT]};
  assign dy = {1'b0, vals_r[NB_UP]}    - {1'b0, vals_r[NB_DOWN]};
  assign dz = {1'b0, vals_r[NB_FRONT]} - {1'b0, vals_r[NB_BACK]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {5'b0, dz, dy, dx,
                     vals_r[NB_BACK], vals_r[NB_FRONT], vals_r[NB_DOWN],
                     vals_r[NB_UP], vals_r[NB_LEFT], vals_r[NB_RIGHT]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_diff_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[56:48] == ({1'b0, out_tdata[7:0]} - {1'b0, out_tdata[15:8]}))
    else $error("diff_x does not match right minus left");

  a_rd_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == ST_RD))
    else $error("read data captured without a read issued");

  a_done_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_DONE) |-> $past(state_r == ST_LAST))
    else $error("result loaded before all six reads returned");

  a_no_wr_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> $past(in_acc) && $past(in_tuser[0] == CMD_WRITE))
    else $error("RAM written outside a write transaction");
`endif

endmodule
`default_nettype wire
